// ----- src/vsm_pkg.sv -----
package vsm_pkg;

    localparam int VEL_W   = 16;
    localparam int TIME_W  = 32;
    localparam int TO_W    = 16;
    localparam int MAX_W   = 15;
    localparam int PWM_W   = 8;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 3;
    localparam int CNT_W   = 4;
    localparam int IN_W    = 64;
    localparam int OP_W    = 2;
    localparam int SRC_W   = 2;
    localparam int BYTE_W  = 8;

    localparam logic [OP_W-1:0] OP_DIRECT = 2'd0;
    localparam logic [OP_W-1:0] OP_FSM    = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [SRC_W-1:0] SRC_NONE   = 2'd0;
    localparam logic [SRC_W-1:0] SRC_DIRECT = 2'd1;
    localparam logic [SRC_W-1:0] SRC_FSM    = 2'd2;

    localparam logic [ADDR_W-1:0] REG_DIRECT_TIMEOUT = 3'd0;
    localparam logic [ADDR_W-1:0] REG_FSM_TIMEOUT    = 3'd1;
    localparam logic [ADDR_W-1:0] REG_RECENT_TIMEOUT = 3'd2;
    localparam logic [ADDR_W-1:0] REG_LINEAR_MAX     = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ANGULAR_MAX    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_PWM_LIMIT      = 3'd5;
    localparam logic [ADDR_W-1:0] REG_ALLOW_REVERSE  = 3'd6;
    localparam logic [ADDR_W-1:0] REG_ANGULAR_FIRST  = 3'd7;

    localparam logic [TO_W-1:0]  RST_DIRECT_TIMEOUT = 16'd250;
    localparam logic [TO_W-1:0]  RST_FSM_TIMEOUT    = 16'd250;
    localparam logic [TO_W-1:0]  RST_RECENT_TIMEOUT = 16'd500;
    localparam logic [MAX_W-1:0] RST_LINEAR_MAX     = 15'd1229;
    localparam logic [MAX_W-1:0] RST_ANGULAR_MAX    = 15'd6144;
    localparam logic [PWM_W-1:0] RST_PWM_LIMIT      = 8'd127;

    localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ANG_P = 8'h41;
    localparam logic [BYTE_W-1:0] CH_ANG_N = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LIN_P = 8'h42;
    localparam logic [BYTE_W-1:0] CH_LIN_N = 8'h62;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_HEX_A = 8'h37;

    localparam logic [CNT_W-1:0] DIV_LAST  = 4'd7;
    localparam logic [CNT_W-1:0] BYTE_LAST = 4'd9;
    localparam logic [CNT_W-1:0] CMD_LEN   = 4'd5;

    typedef struct packed {
        logic             accept;
        logic             diff;
        logic             eval;
        logic             prep;
        logic             mul;
        logic             div_step;
        logic             store;
        logic             sel_ang;
        logic             load_out;
        logic [CNT_W-1:0] byte_idx;
    } vsm_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } vsm_stat_t;

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] d);
        logic [BYTE_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'b0, d};
        end
        else
        begin
            c = CH_HEX_A + {4'b0, d};
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] cmd_byte(
        input logic [CNT_W-1:0] idx,
        input logic             ang_first,
        input logic [PWM_W-1:0] lin_mag,
        input logic             lin_neg,
        input logic [PWM_W-1:0] ang_mag,
        input logic             ang_neg
    );
        logic             second;
        logic             use_ang;
        logic [CNT_W-1:0] pos;
        logic [PWM_W-1:0] mag;
        logic [BYTE_W-1:0] prefix;
        logic [BYTE_W-1:0] b;
        second  = (idx >= CMD_LEN);
        pos     = second ? (idx - CMD_LEN) : idx;
        use_ang = ang_first ^ second;
        mag     = use_ang ? ang_mag : lin_mag;
        if (use_ang)
        begin
            prefix = ang_neg ? CH_ANG_N : CH_ANG_P;
        end
        else
        begin
            prefix = lin_neg ? CH_LIN_N : CH_LIN_P;
        end
        case (pos)
            4'd0:    b = CH_BANG;
            4'd1:    b = prefix;
            4'd2:    b = hex_char(mag[7:4]);
            4'd3:    b = hex_char(mag[3:0]);
            4'd4:    b = CH_CR;
            default: b = CH_CR;
        endcase
        return b;
    endfunction

endpackage

// ----- src/velocity_source_mux_pwm_command.sv -----
// Velocity source selector with PWM motor command encoder.
// Input stream (s_*): one transaction per event. s_tuser is the operation:
// direct command, state machine command or control tick. Command transactions
// update their source slot and produce nothing.
// A tick picks the direct slot if fresh, else the state machine slot if fresh,
// else sends one stop command; it produces ten ASCII bytes on the output
// stream (m_*), two commands "!<A|a|B|b><hex><hex>CR", m_tlast on the tenth.
// A tick that only repeats a stop produces nothing.
// A tick that produces bytes first selects and scales (two passes of a
// multiply and an 8-step restoring divider) and then loads the output
// register, one byte per cycle while the receiver does not stall.
// s_tready is low while a tick is in work; when the receiver stalls, the
// output register holds its byte and the sequencer waits.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce.
// Reset loads the default register values, clears both slots and the stop
// flag, and empties the output register.
module velocity_source_mux_pwm_command
    import vsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // lin_vel, ang_vel, now_ms
    input  logic [OP_W-1:0]   s_tuser,   // operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // tx_byte
    output logic              m_tlast,
    output logic [SRC_W-1:0]  m_tuser    // active_source
);

    vsm_cmd_t  cmd;
    vsm_stat_t stat;

    vsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vsm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- src/vsm_ctrl.sv -----
module vsm_ctrl
    import vsm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic [OP_W-1:0] s_tuser,
    output logic            s_tready,
    input  vsm_stat_t       stat,
    output vsm_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_STORE = 3'd6;
    localparam logic [2:0] S_SEND  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sel_ang_reg, sel_ang_next;
    logic             accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_ang_next = sel_ang_reg;
        cmd          = '0;
        cmd.sel_ang  = sel_ang_reg;
        cmd.byte_idx = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = accept;
                if (accept && (s_tuser == OP_TICK))
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval     = 1'b1;
                sel_ang_next = 1'b0;
                state_next   = stat.emit ? S_PREP : S_IDLE;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                cnt_next  = '0;
                if (!sel_ang_reg)
                begin
                    sel_ang_next = 1'b1;
                    state_next   = S_PREP;
                end
                else
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cnt_next     = cnt_reg + 4'd1;
                    if (cnt_reg == BYTE_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            sel_ang_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sel_ang_reg <= sel_ang_next;
        end
    end

endmodule

// ----- src/vsm_datapath.sv -----
module vsm_datapath
    import vsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]   s_tuser,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic [SRC_W-1:0]  m_tuser,
    input  vsm_cmd_t          cmd,
    output vsm_stat_t         stat
);

    // configuration
    logic [TO_W-1:0]  direct_timeout_reg, fsm_timeout_reg, recent_timeout_reg;
    logic [MAX_W-1:0] linear_max_reg, angular_max_reg;
    logic [PWM_W-1:0] pwm_limit_reg;
    logic             allow_reverse_reg, angular_first_reg;

    // source slots
    logic                    direct_valid_reg, fsm_valid_reg, stop_sent_reg;
    logic signed [VEL_W-1:0] direct_lin_reg, direct_ang_reg, fsm_lin_reg, fsm_ang_reg;
    logic [TIME_W-1:0]       direct_stamp_reg, fsm_stamp_reg, now_reg;
    logic [TIME_W-1:0]       ddiff_reg, fdiff_reg;

    // scaling
    logic [SRC_W-1:0]        src_reg;
    logic signed [VEL_W-1:0] work_lin_reg;
    logic signed [VEL_W:0]   work_ang_reg;
    logic [MAX_W-1:0]        a_reg, m_reg;
    logic                    neg_reg;
    logic [15:0]             rem_reg;
    logic [PWM_W-1:0]        quo_reg;
    logic [PWM_W-1:0]        lin_mag_reg, ang_mag_reg;
    logic                    lin_neg_reg, ang_neg_reg;

    // output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic [SRC_W-1:0]  out_src_reg;

    logic                    d_fresh, f_fresh, dr_fresh, fr_fresh;
    logic [SRC_W-1:0]        src_next;
    logic                    stop_next;
    logic signed [VEL_W-1:0] lin_sel, ang_sel;
    logic signed [VEL_W:0]   v, mm, c, abs_c;
    logic [MAX_W-1:0]        m_sel;
    logic [22:0]             prod;
    logic [23:0]             num;
    logic [15:0]             dvs;
    logic [16:0]             rem2;
    logic                    ge;
    logic [PWM_W-1:0]        mag;

    assign d_fresh  = direct_valid_reg &&
                      ((direct_timeout_reg == '0) || (ddiff_reg <= {16'b0, direct_timeout_reg}));
    assign f_fresh  = fsm_valid_reg &&
                      ((fsm_timeout_reg == '0) || (fdiff_reg <= {16'b0, fsm_timeout_reg}));
    assign dr_fresh = direct_valid_reg && (ddiff_reg <= {16'b0, recent_timeout_reg});
    assign fr_fresh = fsm_valid_reg && (fdiff_reg <= {16'b0, recent_timeout_reg});

    always_comb
    begin
        if (d_fresh)
        begin
            src_next = SRC_DIRECT;
            lin_sel  = direct_lin_reg;
            ang_sel  = direct_ang_reg;
        end
        else if (f_fresh)
        begin
            src_next = SRC_FSM;
            lin_sel  = fsm_lin_reg;
            ang_sel  = fsm_ang_reg;
        end
        else
        begin
            src_next = SRC_NONE;
            lin_sel  = '0;
            ang_sel  = '0;
        end
        if (!allow_reverse_reg && lin_sel[VEL_W-1])
        begin
            lin_sel = '0;
        end
        if (src_next != SRC_NONE)
        begin
            stop_next = 1'b0;
        end
        else if ((recent_timeout_reg != '0) && (dr_fresh || fr_fresh))
        begin
            stop_next = 1'b0;
        end
        else
        begin
            stop_next = 1'b1;
        end
    end

    assign stat.emit     = d_fresh || f_fresh || !stop_sent_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

    // clamp to full scale and take the magnitude
    always_comb
    begin
        v     = cmd.sel_ang ? work_ang_reg : {work_lin_reg[VEL_W-1], work_lin_reg};
        m_sel = cmd.sel_ang ? angular_max_reg : linear_max_reg;
        mm    = $signed({2'b00, m_sel});
        if (v > mm)
        begin
            c = mm;
        end
        else if (v < -mm)
        begin
            c = -mm;
        end
        else
        begin
            c = v;
        end
        abs_c = c[VEL_W] ? -c : c;
    end

    assign prod = {8'b0, a_reg} * {15'b0, pwm_limit_reg};
    assign num  = {prod, 1'b0} + {9'b0, m_reg};
    assign dvs  = {m_reg, 1'b0};
    assign rem2 = {rem_reg, quo_reg[PWM_W-1]};
    assign ge   = (rem2 >= {1'b0, dvs});
    assign mag  = (m_reg == '0) ? '0 : ((quo_reg > pwm_limit_reg) ? pwm_limit_reg : quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_timeout_reg <= RST_DIRECT_TIMEOUT;
            fsm_timeout_reg    <= RST_FSM_TIMEOUT;
            recent_timeout_reg <= RST_RECENT_TIMEOUT;
            linear_max_reg     <= RST_LINEAR_MAX;
            angular_max_reg    <= RST_ANGULAR_MAX;
            pwm_limit_reg      <= RST_PWM_LIMIT;
            allow_reverse_reg  <= 1'b1;
            angular_first_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DIRECT_TIMEOUT: direct_timeout_reg <= cfg_wdata;
                REG_FSM_TIMEOUT:    fsm_timeout_reg    <= cfg_wdata;
                REG_RECENT_TIMEOUT: recent_timeout_reg <= cfg_wdata;
                REG_LINEAR_MAX:     linear_max_reg     <= cfg_wdata[MAX_W-1:0];
                REG_ANGULAR_MAX:    angular_max_reg    <= cfg_wdata[MAX_W-1:0];
                REG_PWM_LIMIT:      pwm_limit_reg      <= cfg_wdata[PWM_W-1:0];
                REG_ALLOW_REVERSE:  allow_reverse_reg  <= cfg_wdata[0];
                REG_ANGULAR_FIRST:  angular_first_reg  <= cfg_wdata[0];
                default:            angular_first_reg  <= angular_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_valid_reg <= 1'b0;
            direct_lin_reg   <= '0;
            direct_ang_reg   <= '0;
            direct_stamp_reg <= '0;
            fsm_valid_reg    <= 1'b0;
            fsm_lin_reg      <= '0;
            fsm_ang_reg      <= '0;
            fsm_stamp_reg    <= '0;
            stop_sent_reg    <= 1'b0;
            src_reg          <= SRC_NONE;
        end
        else
        begin
            if (cmd.accept && (s_tuser == OP_DIRECT))
            begin
                direct_valid_reg <= 1'b1;
                direct_lin_reg   <= s_tdata[15:0];
                direct_ang_reg   <= s_tdata[31:16];
                direct_stamp_reg <= s_tdata[63:32];
            end
            if (cmd.accept && (s_tuser == OP_FSM))
            begin
                fsm_valid_reg <= 1'b1;
                fsm_lin_reg   <= s_tdata[15:0];
                fsm_ang_reg   <= s_tdata[31:16];
                fsm_stamp_reg <= s_tdata[63:32];
            end
            if (cmd.eval)
            begin
                stop_sent_reg <= stop_next;
                src_reg       <= src_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            now_reg <= s_tdata[63:32];
        end
        if (cmd.diff)
        begin
            ddiff_reg <= now_reg - direct_stamp_reg;
            fdiff_reg <= now_reg - fsm_stamp_reg;
        end
        if (cmd.eval)
        begin
            work_lin_reg <= lin_sel;
            work_ang_reg <= -{ang_sel[VEL_W-1], ang_sel};
        end
        if (cmd.prep)
        begin
            a_reg   <= abs_c[MAX_W-1:0];
            neg_reg <= c[VEL_W];
            m_reg   <= m_sel;
        end
        if (cmd.mul)
        begin
            rem_reg <= num[23:8];
            quo_reg <= num[7:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? 16'(rem2 - {1'b0, dvs}) : rem2[15:0];
            quo_reg <= {quo_reg[PWM_W-2:0], ge};
        end
        if (cmd.store)
        begin
            if (cmd.sel_ang)
            begin
                ang_mag_reg <= mag;
                ang_neg_reg <= neg_reg && (mag != '0);
            end
            else
            begin
                lin_mag_reg <= mag;
                lin_neg_reg <= neg_reg && (mag != '0);
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= cmd_byte(cmd.byte_idx, angular_first_reg,
                                     lin_mag_reg, lin_neg_reg, ang_mag_reg, ang_neg_reg);
            out_last_reg <= (cmd.byte_idx == BYTE_LAST);
            out_src_reg  <= src_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_src_reg;

endmodule

// ----- src/vsm_check.sv -----
module vsm_check
    import vsm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [OP_W-1:0]   s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic [SRC_W-1:0]  m_tuser
);

    // output holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output changed while stalled");

    // every command ends in a carriage return, so the last byte is one
    a_last_cr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == CH_CR)
        else $error("last byte is not a carriage return");

    a_src_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == SRC_NONE) || (m_tuser == SRC_DIRECT) || (m_tuser == SRC_FSM))
        else $error("bad source code");

    // a tick blocks the input while it is evaluated
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_TICK) |=> !s_tready)
        else $error("input ready right after a tick");

endmodule

bind velocity_source_mux_pwm_command vsm_check u_vsm_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ----- test/velocity_source_mux_pwm_command_tb.sv -----
module velocity_source_mux_pwm_command_tb;
    import vsm_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              last;
        logic [SRC_W-1:0]  src;
    } stream_byte_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [OP_W-1:0]   s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;
    logic [SRC_W-1:0]  m_tuser;

    // shadow registers
    logic [TO_W-1:0]  dir_limit;
    logic [TO_W-1:0]  fsm_limit;
    logic [TO_W-1:0]  recent_limit;
    logic [MAX_W-1:0] lin_full;
    logic [MAX_W-1:0] ang_full;
    logic [PWM_W-1:0] duty_cap;
    logic             rev_ok;
    logic             ang_leads;

    // source slots
    logic              dir_ok;
    logic [VEL_W-1:0]  dir_lin;
    logic [VEL_W-1:0]  dir_ang;
    logic [TIME_W-1:0] dir_stamp;
    logic              fsm_ok;
    logic [VEL_W-1:0]  fsm_lin;
    logic [VEL_W-1:0]  fsm_ang;
    logic [TIME_W-1:0] fsm_stamp;
    logic              stop_sent;

    stream_byte_t cmd_stream_q[$];
    stream_byte_t want;
    int           mismatches;
    int           cycle_count;
    logic         steady;
    logic [TIME_W-1:0] ms_now;

    velocity_source_mux_pwm_command DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_recent(input logic ok, input logic [TIME_W-1:0] stamp,
                                     input logic [TO_W-1:0] lim,
                                     input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        age = now - stamp;
        return ok && (lim == '0 || age <= {16'd0, lim});
    endfunction

    // rounded scaling to a signed duty value
    function automatic int to_duty(input int v, input int full, input int cap);
        int                c;
        longint unsigned   a;
        longint unsigned   q;
        if (full == 0)
        begin
            return 0;
        end
        c = v;
        if (c > full)
        begin
            c = full;
        end
        if (c < -full)
        begin
            c = -full;
        end
        a = (c < 0) ? longint'(-c) : longint'(c);
        q = (64'd2 * a * longint'(cap) + longint'(full)) / (64'd2 * longint'(full));
        if (q > longint'(cap))
        begin
            q = cap;
        end
        return (c < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic logic [BYTE_W-1:0] hex_ascii(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'h30 + {4'd0, n};
        end
        return 8'h41 + {4'd0, n} - 8'd10;
    endfunction

    function automatic void append_byte(input stream_byte_t b);
        cmd_stream_q.insert(cmd_stream_q.size(), b);
    endfunction

    function automatic void queue_command(input int duty, input logic [BYTE_W-1:0] pos,
                                          input logic [BYTE_W-1:0] neg,
                                          input logic [SRC_W-1:0] src, input logic second);
        logic [PWM_W-1:0] mag;
        mag = (duty < 0) ? PWM_W'(-duty) : PWM_W'(duty);
        append_byte(stream_byte_t'{CH_BANG, 1'b0, src});
        append_byte(stream_byte_t'{(duty < 0) ? neg : pos, 1'b0, src});
        append_byte(stream_byte_t'{hex_ascii(mag[7:4]), 1'b0, src});
        append_byte(stream_byte_t'{hex_ascii(mag[3:0]), 1'b0, src});
        append_byte(stream_byte_t'{CH_CR, second, src});
    endfunction

    function automatic void queue_motion(input logic [VEL_W-1:0] lin_raw,
                                         input logic [VEL_W-1:0] ang_raw,
                                         input logic [SRC_W-1:0] src);
        int lin;
        int ang;
        int lin_duty;
        int ang_duty;
        lin = $signed(lin_raw);
        ang = $signed(ang_raw);
        if (!rev_ok && lin < 0)
        begin
            lin = 0;
        end
        lin_duty = to_duty(lin, int'(lin_full), int'(duty_cap));
        ang_duty = to_duty(-ang, int'(ang_full), int'(duty_cap));
        if (ang_leads)
        begin
            queue_command(ang_duty, CH_ANG_P, CH_ANG_N, src, 1'b0);
            queue_command(lin_duty, CH_LIN_P, CH_LIN_N, src, 1'b1);
        end
        else
        begin
            queue_command(lin_duty, CH_LIN_P, CH_LIN_N, src, 1'b0);
            queue_command(ang_duty, CH_ANG_P, CH_ANG_N, src, 1'b1);
        end
    endfunction

    // source selection and command encoding for one accepted transaction
    function automatic void mux_and_encode(input logic [OP_W-1:0] op,
                                           input logic [VEL_W-1:0] lin,
                                           input logic [VEL_W-1:0] ang,
                                           input logic [TIME_W-1:0] now);
        case (op)
            OP_DIRECT:
            begin
                dir_lin   = lin;
                dir_ang   = ang;
                dir_stamp = now;
                dir_ok    = 1'b1;
            end
            OP_FSM:
            begin
                fsm_lin   = lin;
                fsm_ang   = ang;
                fsm_stamp = now;
                fsm_ok    = 1'b1;
            end
            OP_TICK:
            begin
                if (is_recent(dir_ok, dir_stamp, dir_limit, now))
                begin
                    stop_sent = 1'b0;
                    queue_motion(dir_lin, dir_ang, SRC_DIRECT);
                end
                else if (is_recent(fsm_ok, fsm_stamp, fsm_limit, now))
                begin
                    stop_sent = 1'b0;
                    queue_motion(fsm_lin, fsm_ang, SRC_FSM);
                end
                else
                begin
                    if (!stop_sent)
                    begin
                        queue_motion('0, '0, SRC_NONE);
                        stop_sent = 1'b1;
                    end
                    if (recent_limit != '0 &&
                        (is_recent(dir_ok, dir_stamp, recent_limit, now) ||
                         is_recent(fsm_ok, fsm_stamp, recent_limit, now)))
                    begin
                        stop_sent = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("velocity_source_mux_pwm_command test failed");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cmd_stream_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected byte, actual %h last %b source %0d",
                         $time, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = cmd_stream_q.pop_front();
                if (m_tdata !== want.ch)
                begin
                    mismatches++;
                    $display("%0t: tx_byte expected %h actual %h", $time, want.ch, m_tdata);
                end
                if (m_tlast !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last_byte expected %b actual %b",
                             $time, want.last, m_tlast);
                end
                if (m_tuser !== want.src)
                begin
                    mismatches++;
                    $display("%0t: active_source expected %0d actual %0d",
                             $time, want.src, m_tuser);
                end
            end
        end
    end

    task automatic send_event(input logic [OP_W-1:0] op, input logic [VEL_W-1:0] lin,
                              input logic [VEL_W-1:0] ang, input logic [TIME_W-1:0] now);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, ang, lin};
        s_tuser  <= op;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        mux_and_encode(op, lin, ang, now);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (cmd_stream_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DIRECT_TIMEOUT: dir_limit    = val;
            REG_FSM_TIMEOUT:    fsm_limit    = val;
            REG_RECENT_TIMEOUT: recent_limit = val;
            REG_LINEAR_MAX:     lin_full     = val[MAX_W-1:0];
            REG_ANGULAR_MAX:    ang_full     = val[MAX_W-1:0];
            REG_PWM_LIMIT:      duty_cap     = val[PWM_W-1:0];
            REG_ALLOW_REVERSE:  rev_ok       = val[0];
            REG_ANGULAR_FIRST:  ang_leads    = val[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_registers(input int d_to, input int f_to, input int r_to,
                                 input int l_max, input int a_max, input int cap,
                                 input int rev, input int ang_first);
        wait_idle();
        write_reg(REG_DIRECT_TIMEOUT, CFG_W'(d_to));
        write_reg(REG_FSM_TIMEOUT,    CFG_W'(f_to));
        write_reg(REG_RECENT_TIMEOUT, CFG_W'(r_to));
        write_reg(REG_LINEAR_MAX,     CFG_W'(l_max));
        write_reg(REG_ANGULAR_MAX,    CFG_W'(a_max));
        write_reg(REG_PWM_LIMIT,      CFG_W'(cap));
        write_reg(REG_ALLOW_REVERSE,  CFG_W'(rev));
        write_reg(REG_ANGULAR_FIRST,  CFG_W'(ang_first));
    endtask

    function automatic logic [VEL_W-1:0] pick_velocity(input logic [MAX_W-1:0] full);
        int r;
        if ($urandom_range(0, 1))
        begin
            return VEL_W'($urandom);
        end
        r = int'($urandom_range(0, 2 * int'(full) + 200)) - int'(full) - 100;
        return r[VEL_W-1:0];
    endfunction

    task automatic run_random_events(input int count, input int calm_from, input int calm_to);
        int                k;
        int                pick;
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] stamp;
        for (k = 0; k < count; k++)
        begin
            steady = (k >= calm_from && k < calm_to);
            if ($urandom_range(0, 99) < 3)
            begin
                ms_now = $urandom;
            end
            else
            begin
                ms_now = ms_now + $urandom_range(0, 300);
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                op = OP_DIRECT;
            end
            else if (pick < 55)
            begin
                op = OP_FSM;
            end
            else if (pick < 96)
            begin
                op = OP_TICK;
            end
            else
            begin
                op = OP_UNUSED;
            end
            stamp = ms_now;
            // occasional command stamped in the future
            if (op != OP_TICK && $urandom_range(0, 19) == 0)
            begin
                stamp = ms_now + $urandom_range(1, 2000);
            end
            send_event(op, pick_velocity(lin_full), pick_velocity(ang_full), stamp);
        end
        steady = 1'b0;
    endtask

    task automatic test_stop_and_rearm();
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd1000);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd1010);
        send_event(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd1030);
        send_event(OP_DIRECT, 16'h7FFF, 16'h8000, 32'd1100);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd1100);
        // edge of the direct window, then just past it
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd1350);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd1351);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd1400);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd1601);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd1700);
        send_event(OP_FSM,    16'h8000, 16'h7FFF, 32'd2000);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd2000);
        send_event(OP_DIRECT, 16'h0000, 16'h0000, 32'd2100);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd2150);
        send_event(OP_DIRECT, 16'h0400, 16'hFC00, 32'd5000);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'd2200);
        // time wraps between command and tick
        send_event(OP_FSM,    16'hFFFF, 16'h0001, 32'hFFFF_FF80);
        send_event(OP_TICK,   16'h0000, 16'h0000, 32'h0000_0040);
        ms_now = 32'h0000_0040;
    endtask

    task automatic test_register_settings();
        set_registers(0, 0, 0, 0, 0, 255, 0, 0);
        run_random_events(10, 0, 0);
        set_registers(65535, 65535, 65535, 32767, 32767, 255, 1, 1);
        run_random_events(10, 0, 0);
        set_registers(10, 10, 0, 1, 1, 0, 0, 1);
        run_random_events(10, 0, 0);
        set_registers(100, 300, 1000, 1024, 3000, 200, 0, 0);
        run_random_events(10, 0, 0);
        set_registers($urandom_range(1, 600), $urandom_range(1, 600), $urandom_range(0, 1200),
                      $urandom_range(1, 32767), $urandom_range(1, 32767),
                      $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1));
        run_random_events(10, 0, 0);
        set_registers(RST_DIRECT_TIMEOUT, RST_FSM_TIMEOUT, RST_RECENT_TIMEOUT,
                      RST_LINEAR_MAX, RST_ANGULAR_MAX, RST_PWM_LIMIT, 1, 1);
        run_random_events(10, 0, 0);
    endtask

    task automatic test_random_traffic();
        run_random_events(80, 30, 55);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_DIRECT;
        steady       = 1'b0;
        mismatches   = 0;
        cycle_count  = 0;
        ms_now       = '0;
        dir_limit    = RST_DIRECT_TIMEOUT;
        fsm_limit    = RST_FSM_TIMEOUT;
        recent_limit = RST_RECENT_TIMEOUT;
        lin_full     = RST_LINEAR_MAX;
        ang_full     = RST_ANGULAR_MAX;
        duty_cap     = RST_PWM_LIMIT;
        rev_ok       = 1'b1;
        ang_leads    = 1'b1;
        dir_ok       = 1'b0;
        dir_lin      = '0;
        dir_ang      = '0;
        dir_stamp    = '0;
        fsm_ok       = 1'b0;
        fsm_lin      = '0;
        fsm_ang      = '0;
        fsm_stamp    = '0;
        stop_sent    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_stop_and_rearm();
        test_register_settings();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0 && cmd_stream_q.size() == 0)
        begin
            $display("velocity_source_mux_pwm_command test passed");
        end
        else
        begin
            $display("velocity_source_mux_pwm_command test failed");
        end
        $finish;
    end

endmodule
